// ===== rtl/rtpjs_pkg.sv =====
// Shared types and constants for the RTP jitter statistics block.
// Used by rtpjs_delta, rtp_jitter_statistics, rtpjs_checker and the bench; depends on nothing.
package rtpjs_pkg;

  // Event kinds carried in tuser
  localparam logic [1:0] OP_PACKET = 2'd0;
  localparam logic [1:0] OP_FRAME  = 2'd1;
  localparam logic [1:0] OP_LOST   = 2'd2;

  localparam int CNT_W   = 48;  // wrapping event counters
  localparam int ACC_W   = 40;  // Q8 accumulators
  localparam int FRAC_W  = 8;   // fraction bits of the accumulators
  localparam int JIT_SH  = 4;   // jitter gain 1/16
  localparam int GAP_SH  = 8;   // gap average gain 1/256

  // floor(x/9) = (x * RECIP9) >> RECIP9_SH, exact for any 32-bit x
  localparam logic [29:0] RECIP9    = 30'h38E38E39;
  localparam int          RECIP9_SH = 33;

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 272;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] arrival_us;
    logic [31:0] rtp_stamp;
    logic        frame_incomplete;
    logic [15:0] lost_count;
  } rtpjs_item_t;

  // Per-event deltas handed to the accumulator stage
  typedef struct packed {
    logic [1:0]         op;
    logic               upd;        // packet with a previous packet
    logic               frame_incomplete;
    logic [15:0]        lost_count;
    logic signed [31:0] d_arr;      // saturated arrival delta, us
    logic [31:0]        diff;       // |d_arr - d_rtp|, saturated
  } rtpjs_delta_t;

endpackage

// ===== rtl/rtp_jitter_statistics.sv =====
// Receive-side RTP statistics: delta pipeline plus accumulator/output stage.
// Depends on rtpjs_pkg and rtpjs_delta.
// Throughput: one event per cycle, sustained, as long as m_tready stays high.
// The snapshot for an event is valid once the event has passed the input register,
//   product register, difference register and output register.
// The 32x30 reciprocal multiply for /9 sets the stage split of the front end.
// Reset (rst, synchronous): all counters, averages and previous values clear.
module rtp_jitter_statistics
  import rtpjs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // s_tdata: arrival_us[63:0], rtp_stamp[95:64], frame_incomplete[96],
  //          lost_count[112:97], zero pad[119:113]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // s_tuser: op[1:0]
  input  logic [1:0]            s_tuser,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // m_tdata: frames_total[47:0], frames_bad[95:48], packets_total[143:96],
  //          packets_missing[191:144], jitter_q8[231:192], gap_avg_q8[271:232]
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready
);

  rtpjs_item_t  in_item;
  rtpjs_delta_t dl;
  logic         dl_valid;
  logic         dl_ready;

  // Statistics state; it is also the snapshot shown on m_tdata, since it
  // only moves when a new snapshot is loaded.
  logic [CNT_W-1:0]        frame_count, frame_count_next;
  logic [CNT_W-1:0]        bad_count, bad_count_next;
  logic [CNT_W-1:0]        packet_count, packet_count_next;
  logic [CNT_W-1:0]        lost_total, lost_total_next;
  logic [ACC_W-1:0]        jitter_acc, jitter_acc_next;
  logic signed [ACC_W-1:0] gap_acc, gap_acc_next;

  logic [ACC_W-1:0]        xj;
  logic signed [ACC_W-1:0] xg;
  logic signed [ACC_W:0]   dj, dg, jsum, gsum;

  assign in_item.op               = s_tuser;
  assign in_item.arrival_us       = s_tdata[63:0];
  assign in_item.rtp_stamp        = s_tdata[95:64];
  assign in_item.frame_incomplete = s_tdata[96];
  assign in_item.lost_count       = s_tdata[112:97];

  rtpjs_delta u_delta (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_item  (dl),
    .out_valid (dl_valid),
    .out_ready (dl_ready)
  );

  // output register is free, or its snapshot leaves this cycle
  assign dl_ready = !m_tvalid || m_tready;

  // Q8 low-pass filters; >>> on the signed error is the floor shift.
  always_comb begin
    xj   = {dl.diff, {FRAC_W{1'b0}}};
    xg   = {dl.d_arr, {FRAC_W{1'b0}}};
    dj   = $signed({1'b0, xj}) - $signed({1'b0, jitter_acc});
    dg   = $signed({xg[ACC_W-1], xg}) - $signed({gap_acc[ACC_W-1], gap_acc});
    jsum = $signed({1'b0, jitter_acc}) + (dj >>> JIT_SH);
    gsum = $signed({gap_acc[ACC_W-1], gap_acc}) + (dg >>> GAP_SH);
  end

  always_comb begin
    frame_count_next  = frame_count;
    bad_count_next    = bad_count;
    packet_count_next = packet_count;
    lost_total_next   = lost_total;
    jitter_acc_next   = jitter_acc;
    gap_acc_next      = gap_acc;
    case (dl.op)
      OP_PACKET: begin
        packet_count_next = packet_count + CNT_W'(1);
        if (dl.upd) begin
          jitter_acc_next = jsum[ACC_W-1:0];
          gap_acc_next    = gsum[ACC_W-1:0];
        end
      end
      OP_FRAME: begin
        frame_count_next = frame_count + CNT_W'(1);
        bad_count_next   = bad_count + CNT_W'(dl.frame_incomplete);
      end
      OP_LOST: begin
        lost_total_next = lost_total + CNT_W'(dl.lost_count);
      end
      default: begin
        // unused kind: snapshot only
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid     <= 1'b0;
      frame_count  <= '0;
      bad_count    <= '0;
      packet_count <= '0;
      lost_total   <= '0;
      jitter_acc   <= '0;
      gap_acc      <= '0;
    end else if (dl_ready) begin
      m_tvalid <= dl_valid;
      if (dl_valid) begin
        frame_count  <= frame_count_next;
        bad_count    <= bad_count_next;
        packet_count <= packet_count_next;
        lost_total   <= lost_total_next;
        jitter_acc   <= jitter_acc_next;
        gap_acc      <= gap_acc_next;
      end
    end
  end

  assign m_tdata = {gap_acc, jitter_acc, lost_total, packet_count, bad_count, frame_count};

endmodule

// ===== rtl/rtpjs_delta.sv =====
// Delta front end: arrival and RTP deltas and their absolute difference.
// Three pipeline stages with bubble collapse; depends on rtpjs_pkg.
module rtpjs_delta
  import rtpjs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  rtpjs_item_t  in_item,
  input  logic         in_valid,
  output logic         in_ready,
  output rtpjs_delta_t out_item,
  output logic         out_valid,
  input  logic         out_ready
);

  typedef struct packed {
    logic [1:0]         op;
    logic               upd;
    logic               frame_incomplete;
    logic [15:0]        lost_count;
    logic signed [31:0] d_arr;
    logic [28:0]        q9;       // floor(drts/9)
    logic [35:0]        drts11;   // drts*11
  } mid_t;

  rtpjs_item_t  s1;
  mid_t         s2;
  rtpjs_delta_t s3;
  logic         v1, v2, v3;
  logic         ready1, ready2, ready3;

  logic        seen;
  logic [63:0] prev_arrival;
  logic [31:0] prev_stamp;

  logic [63:0] raw;
  logic [31:0] drts;
  logic [61:0] prod;
  mid_t        s2_next;

  logic [35:0] d_rtp;
  logic [37:0] sd;
  logic [37:0] mag;
  rtpjs_delta_t s3_next;

  assign ready3   = !v3 || out_ready;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  // stage 1: deltas against the previous packet
  always_comb begin
    raw  = s1.arrival_us - prev_arrival;
    drts = s1.rtp_stamp - prev_stamp;
    prod = {30'd0, drts} * {32'd0, RECIP9};
    s2_next.op               = s1.op;
    s2_next.upd              = seen && (s1.op == OP_PACKET);
    s2_next.frame_incomplete = s1.frame_incomplete;
    s2_next.lost_count       = s1.lost_count;
    if (raw[63] && !(&raw[62:31])) begin
      s2_next.d_arr = 32'sh80000000;
    end else if (!raw[63] && (|raw[62:31])) begin
      s2_next.d_arr = 32'sh7FFFFFFF;
    end else begin
      s2_next.d_arr = raw[31:0];
    end
    s2_next.q9     = prod[RECIP9_SH +: 29];
    s2_next.drts11 = {4'd0, drts} + {1'b0, drts, 3'b000} + {3'b000, drts, 1'b0};
  end

  // stage 2: d_rtp = 11*drts + floor(drts/9), then |d_arr - d_rtp|
  always_comb begin
    d_rtp = s2.drts11 + {7'd0, s2.q9};
    sd    = {{6{s2.d_arr[31]}}, s2.d_arr} - {2'b00, d_rtp};
    mag   = sd[37] ? (38'd0 - sd) : sd;
    s3_next.op               = s2.op;
    s3_next.upd              = s2.upd;
    s3_next.frame_incomplete = s2.frame_incomplete;
    s3_next.lost_count       = s2.lost_count;
    s3_next.d_arr            = s2.d_arr;
    s3_next.diff             = (|mag[37:32]) ? 32'hFFFFFFFF : mag[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      seen         <= 1'b0;
      prev_arrival <= '0;
      prev_stamp   <= '0;
    end else begin
      if (ready1) begin
        v1 <= in_valid;
      end
      if (ready2) begin
        v2 <= v1;
        if (v1 && (s1.op == OP_PACKET)) begin
          seen         <= 1'b1;
          prev_arrival <= s1.arrival_us;
          prev_stamp   <= s1.rtp_stamp;
        end
      end
      if (ready3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      s1 <= in_item;
    end
    if (ready2) begin
      s2 <= s2_next;
    end
    if (ready3) begin
      s3 <= s3_next;
    end
  end

  assign out_item  = s3;
  assign out_valid = v3;

endmodule

// ===== rtl/rtpjs_checker.sv =====
// Port-level checks for rtp_jitter_statistics, attached by bind.
// Depends on rtpjs_pkg for the data width.
module rtpjs_checker
  import rtpjs_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tvalid,
  input logic                  m_tready
);

  // reset empties the block and clears every statistic
  a_reset: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready && (m_tdata == '0)))
    else $error("state not cleared by reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled snapshot changed");

  // consecutive snapshots differ by one event: packet count moves by 0 or 1
  a_pkt_step: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready) ##1 m_tvalid |->
      (48'(m_tdata[143:96] - $past(m_tdata[143:96])) <= 48'd1))
    else $error("packet count jumped");

  // a bad frame is always also a counted frame
  a_bad_frame: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready) ##1 (m_tvalid && (m_tdata[95:48] != $past(m_tdata[95:48]))) |->
      (m_tdata[47:0] == 48'($past(m_tdata[47:0]) + 48'd1)))
    else $error("bad frame without frame");

endmodule

bind rtp_jitter_statistics rtpjs_checker u_rtpjs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

// ===== bench/tb_rtp_jitter_statistics.sv =====
// Self-checking bench for rtp_jitter_statistics: stream driver, result monitor, predictor.
// Depends on rtpjs_pkg (event codes, widths, item layout) and the block's RTL.
module tb_rtp_jitter_statistics;
  timeunit 1ns;
  timeprecision 1ps;
  import rtpjs_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;  // no state change, snapshot only
  localparam int WATCHDOG_LIMIT = 1000;       // cycles with no item moving
  localparam longint DIFF_MAX = 64'h0000_0000_FFFF_FFFF;

  // One snapshot as carried on m_tdata
  typedef struct packed {
    logic [CNT_W-1:0] frames_total;
    logic [CNT_W-1:0] frames_bad;
    logic [CNT_W-1:0] packets_total;
    logic [CNT_W-1:0] packets_missing;
    logic [ACC_W-1:0] jitter_q8;
    logic [ACC_W-1:0] gap_avg_q8;
  } snapshot_t;

  logic                  clk;
  logic                  rst;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [1:0]            s_tuser;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tvalid;
  logic                  m_tready;

  rtp_jitter_statistics dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  rtpjs_item_t event_q[$];      // events waiting for the driver
  snapshot_t   snapshot_q[$];   // snapshots owed by the block, oldest first
  int          mismatches = 0;
  int          src_idle_pct = 0;
  int          snk_stall_pct = 0;
  bit          in_taken = 1'b0;  // item accepted at the last rising edge

  // Predicted receiver state
  bit               seen_pkt = 1'b0;
  logic [31:0]      last_stamp = '0;
  logic [63:0]      last_arrival = '0;
  longint           jit_acc = 0;
  longint           gap_acc = 0;
  logic [CNT_W-1:0] n_frames = '0;
  logic [CNT_W-1:0] n_bad_frames = '0;
  logic [CNT_W-1:0] n_packets = '0;
  logic [CNT_W-1:0] n_lost = '0;

  // Well-formed stream position used by the random stimulus
  logic [63:0] stream_arr;
  logic [31:0] stream_stamp;

  // Applies one event to the predicted state and returns the snapshot after it
  task automatic update_stats(input rtpjs_item_t ev, output snapshot_t snap);
    logic [63:0] raw;
    logic [63:0] neg;
    logic [31:0] dstamp;
    longint      d_arr;
    longint      d_rtp;
    longint      diff;
    case (ev.op)
      OP_PACKET: begin
        n_packets = n_packets + 1'b1;
        if (seen_pkt) begin
          raw = ev.arrival_us - last_arrival;
          if (raw[63]) begin
            neg = -raw;
            d_arr = (neg >= 64'h8000_0000) ? -longint'(64'h8000_0000) : -longint'(neg);
          end else begin
            d_arr = (raw > 64'h7FFF_FFFF) ? longint'(64'h7FFF_FFFF) : longint'(raw);
          end
          // 90 kHz ticks to microseconds, rounded down
          dstamp = ev.rtp_stamp - last_stamp;
          d_rtp = longint'((64'(dstamp) * 64'd100) / 64'd9);
          diff = d_arr - d_rtp;
          if (diff < 0) diff = -diff;
          if (diff > DIFF_MAX) diff = DIFF_MAX;
          // the Q8 sample clamps cannot bind at 32-bit deltas and 40-bit accumulators
          jit_acc = jit_acc + (((diff <<< FRAC_W) - jit_acc) >>> JIT_SH);
          gap_acc = gap_acc + (((d_arr <<< FRAC_W) - gap_acc) >>> GAP_SH);
        end
        last_stamp = ev.rtp_stamp;
        last_arrival = ev.arrival_us;
        seen_pkt = 1'b1;
      end
      OP_FRAME: begin
        n_frames = n_frames + 1'b1;
        if (ev.frame_incomplete) n_bad_frames = n_bad_frames + 1'b1;
      end
      OP_LOST: begin
        n_lost = n_lost + CNT_W'(ev.lost_count);
      end
      default: begin
      end
    endcase
    snap.frames_total    = n_frames;
    snap.frames_bad      = n_bad_frames;
    snap.packets_total   = n_packets;
    snap.packets_missing = n_lost;
    snap.jitter_q8       = jit_acc[ACC_W-1:0];
    snap.gap_avg_q8      = gap_acc[ACC_W-1:0];
  endtask

  task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  task automatic queue_event(input logic [1:0] op, input logic [63:0] arr,
                             input logic [31:0] stamp, input logic fi,
                             input logic [15:0] lost);
    rtpjs_item_t ev;
    ev.op = op;
    ev.arrival_us = arr;
    ev.rtp_stamp = stamp;
    ev.frame_incomplete = fi;
    ev.lost_count = lost;
    event_q.push_back(ev);
  endtask

  // Mostly a plausible packet stream with frames and loss reports mixed in;
  // the rest is wild timestamps, late packets and the unused op.
  task automatic queue_random_items(input int count);
    int          r;
    int          step;
    int          wobble;
    logic [63:0] wide;
    for (int i = 0; i < count; i++) begin
      r = int'($urandom_range(0, 99));
      wide = {$urandom, $urandom};
      if (r < 60) begin
        step = int'($urandom_range(0, 3000));
        wobble = int'($urandom_range(0, 4000)) - 2000;
        if ($urandom_range(0, 49) == 0) stream_arr = stream_arr + 64'($urandom);
        stream_stamp = stream_stamp + 32'(step);
        stream_arr = stream_arr + (64'(step) * 64'd100) / 64'd9 + 64'(longint'(wobble));
        queue_event(OP_PACKET, stream_arr, stream_stamp, 1'($urandom), 16'($urandom));
      end else if (r < 72) begin
        queue_event(OP_FRAME, wide, $urandom, $urandom_range(0, 3) == 0, 16'($urandom));
      end else if (r < 82) begin
        queue_event(OP_LOST, wide, $urandom, 1'($urandom),
                    ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20)));
      end else if (r < 92) begin
        queue_event(OP_PACKET, wide, $urandom, 1'($urandom), 16'($urandom));
      end else if (r < 97) begin
        // late or reordered packet
        queue_event(OP_PACKET, stream_arr - 64'($urandom_range(0, 5000)),
                    stream_stamp - 32'($urandom_range(0, 500)), 1'($urandom), 16'($urandom));
      end else begin
        queue_event(OP_UNUSED, wide, $urandom, 1'($urandom), 16'($urandom));
      end
    end
  endtask

  // Driver: a new item goes out once the previous one was taken
  always @(negedge clk) begin
    rtpjs_item_t ev;
    if (!rst) begin
      if (!s_tvalid || in_taken) begin
        if (event_q.size() > 0 && int'($urandom_range(0, 99)) >= src_idle_pct) begin
          ev = event_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= ev.op;
          s_tdata  <= {7'b0, ev.lost_count, ev.frame_incomplete, ev.rtp_stamp, ev.arrival_us};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      in_taken = 1'b0;
      m_tready <= int'($urandom_range(0, 99)) >= snk_stall_pct;
    end
  end

  // Monitor: predict on every accepted event, check every accepted snapshot
  always @(posedge clk) begin
    rtpjs_item_t ev;
    snapshot_t   want;
    snapshot_t   got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        ev.op = s_tuser;
        ev.arrival_us = s_tdata[63:0];
        ev.rtp_stamp = s_tdata[95:64];
        ev.frame_incomplete = s_tdata[96];
        ev.lost_count = s_tdata[112:97];
        update_stats(ev, want);
        snapshot_q.push_back(want);
        in_taken = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        got.frames_total    = m_tdata[47:0];
        got.frames_bad      = m_tdata[95:48];
        got.packets_total   = m_tdata[143:96];
        got.packets_missing = m_tdata[191:144];
        got.jitter_q8       = m_tdata[231:192];
        got.gap_avg_q8      = m_tdata[271:232];
        if (snapshot_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected snapshot expected none actual %h", $time, m_tdata);
        end else begin
          want = snapshot_q.pop_front();
          check_field("frames_total", want.frames_total, got.frames_total);
          check_field("frames_bad", want.frames_bad, got.frames_bad);
          check_field("packets_total", want.packets_total, got.packets_total);
          check_field("packets_missing", want.packets_missing, got.packets_missing);
          check_field("jitter_q8", CNT_W'(want.jitter_q8), CNT_W'(got.jitter_q8));
          check_field("gap_avg_q8", CNT_W'(want.gap_avg_q8), CNT_W'(got.gap_avg_q8));
        end
      end
    end
  end

  // Watchdog on cycles where neither side moves an item
  always @(posedge clk) begin
    int quiet;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("tb_rtp_jitter_statistics NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_PACKET;
    m_tready = 1'b0;
    stream_arr = {$urandom, $urandom};
    stream_stamp = $urandom;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 49; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 49; end
        default: begin src_idle_pct = 26; snk_stall_pct = 26; end
      endcase
      if (phase == 0) begin
        // unused op on an empty state, counters at their field extremes
        queue_event(OP_UNUSED, '0, '0, 1'b0, '0);
        queue_event(OP_FRAME, '0, '0, 1'b0, '0);
        queue_event(OP_FRAME, '0, '0, 1'b1, '0);
        queue_event(OP_LOST, '0, '0, 1'b0, 16'h0000);
        queue_event(OP_LOST, '0, '0, 1'b0, 16'hFFFF);
        // first packet only stores its times
        queue_event(OP_PACKET, 64'd0, 32'd0, 1'b0, '0);
        // exact 90 kHz pace: jitter sample of zero
        queue_event(OP_PACKET, 64'd1000, 32'd90, 1'b0, '0);
        // huge forward jump with stamp wrapping one tick short: both clamps
        queue_event(OP_PACKET, 64'h0000_0100_0000_03E8, 32'd89, 1'b0, '0);
        // far backward arrival saturates negative
        queue_event(OP_PACKET, 64'd0, 32'd100, 1'b0, '0);
        queue_event(OP_PACKET, '1, 32'd0, 1'b1, '1);
        queue_event(OP_PACKET, 64'd0, '1, 1'b0, '0);
        queue_event(OP_PACKET, 64'h8000_0000_0000_0000, 32'd1, 1'b0, '0);
        // arrival delta at and just past the positive limit
        queue_event(OP_PACKET, 64'h8000_0000_7FFF_FFFF, 32'd2, 1'b0, '0);
        queue_event(OP_PACKET, 64'h8000_0000_FFFF_FFFF, 32'd3, 1'b0, '0);
        // backward by exactly the negative limit, then one less
        queue_event(OP_PACKET, 64'h8000_0000_7FFF_FFFF, 32'd4, 1'b0, '0);
        queue_event(OP_PACKET, 64'h8000_0000_0000_0000, 32'd5, 1'b0, '0);
        // repeated packet: zero deltas
        queue_event(OP_PACKET, 64'h8000_0000_0000_0000, 32'd5, 1'b0, '0);
        // unused fields all ones
        queue_event(OP_UNUSED, '1, '1, 1'b1, '1);
        queue_event(OP_FRAME, '1, '1, 1'b0, '1);
        queue_event(OP_LOST, '1, '1, 1'b1, 16'd1);
      end
      queue_random_items(470);
      // checked at the rising edge, where the driver's queue and s_tvalid are settled
      while (event_q.size() != 0 || s_tvalid || snapshot_q.size() != 0) @(posedge clk);
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && snapshot_q.size() == 0) begin
      $display("tb_rtp_jitter_statistics OK");
    end else begin
      $display("tb_rtp_jitter_statistics NOT OK");
    end
    $finish;
  end

endmodule
